// ===== rtl/core/chained_hash_map_engine_core_macros.svh =====
// Assertion macros shared by the hash map engine RTL.
`ifndef CHAINED_HASH_MAP_ENGINE_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/chmap_pkg.sv =====
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package chmap_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int HASH_BITS_DEF = 3;

    // bucket count register width as seen on the config port
    localparam int BKT_W = 7;
    localparam logic [BKT_W-1:0] RESET_BUCKETS = 7'd8;

    localparam logic [31:0] FIB_MULT = 32'd2654435769;

    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch request word
        logic search;  // step the key search
        logic update;  // apply put, start bucket recount
        logic scan;    // one hash value of the recount
    } hm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic scan_last;
    } hm_sts_t;

endpackage

// ===== rtl/core/chmap_ctrl.sv =====
// Request sequencer: search, update, bucket recount, result strobe.
`timescale 1ns / 1ps
`include "chained_hash_map_engine_core_macros.svh"
module chmap_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output chmap_pkg::hm_cmd_t cmd,
    input  chmap_pkg::hm_sts_t sts
);
    import chmap_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_UPDATE = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.search_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `CHM_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd), "overlapping datapath commands")
    `CHM_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `CHM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not start")

endmodule

// ===== rtl/core/chmap_dp.sv =====
// Entry store, key search, insert/grow logic and bucket recount datapath.
`timescale 1ns / 1ps
`include "chained_hash_map_engine_core_macros.svh"
module chmap_dp #(
    parameter int ENTRIES   = chmap_pkg::ENTRIES_DEF,
    parameter int HASH_BITS = chmap_pkg::HASH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chmap_pkg::hm_cmd_t          cmd,
    output chmap_pkg::hm_sts_t          sts,
    input  logic                        cfg_wr_en,
    input  logic [chmap_pkg::BKT_W-1:0] cfg_wr_data,
    input  logic                        req_type,
    input  logic [31:0]                 key,
    input  logic [31:0]                 value,
    output logic                        status,
    output logic                        found,
    output logic [31:0]                 value_out,
    output logic [6:0]                  entry_count,
    output logic [5:0]                  collisions
);
    import chmap_pkg::*;

    localparam int AW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int BW   = (CW > BKT_W) ? CW : BKT_W;
    localparam int GW   = BW + 1;
    localparam int HN   = 1 << HASH_BITS;
    localparam int NW   = HASH_BITS + 1;
    localparam int CMPW = (NW > BW) ? NW : BW;
    localparam int WA   = (CW > NW) ? CW : NW;
    localparam int WIDE = (WA > 7) ? WA : 7;

    // request word
    logic        req_reg;
    logic [31:0] key_reg;
    logic [31:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value;
        end
    end

    // Fibonacci hash, registered; settles during the search
    logic [31:0]          mix;
    logic [31:0]          prod;
    logic [HASH_BITS-1:0] hash_reg;

    assign mix  = key_reg ^ (key_reg >> (32 - HASH_BITS));
    assign prod = mix * FIB_MULT;

    always_ff @(posedge clk)
    begin
        hash_reg <= prod[31 -: HASH_BITS];
    end

    // entry store
    logic [31:0] key_mem [ENTRIES];
    logic [31:0] val_mem [ENTRIES];

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] total_reg;
    logic [BW-1:0] bc_reg;
    logic          issue;
    logic          rd_vld_reg;
    logic [31:0]   rd_key_reg;
    logic [31:0]   rd_val_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          hit_reg;
    logic [AW-1:0] slot_reg;
    logic [31:0]   hval_reg;
    logic          match;

    logic          is_put;
    logic          full;
    logic          insert;
    logic          overwrite;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] total_inc;
    logic          grow;
    logic [BW-1:0] cfg_bc;

    assign issue = cmd.search && (idx_reg != total_reg);
    assign match = rd_vld_reg && (rd_key_reg == key_reg);

    assign is_put    = (req_reg == REQ_PUT);
    assign full      = (total_reg == CW'(ENTRIES));
    assign insert    = cmd.update && is_put && !hit_reg && !full;
    assign overwrite = cmd.update && is_put && hit_reg;
    assign wr_addr   = hit_reg ? slot_reg : total_reg[AW-1:0];
    assign total_inc = total_reg + 1'b1;
    assign grow      = (GW'(total_inc) > {bc_reg, 1'b0});
    assign cfg_bc    = (cfg_wr_data == '0) ? BW'(1) : BW'(cfg_wr_data);

    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (insert || overwrite)
        begin
            val_mem[wr_addr] <= val_reg;
        end
        if (issue)
        begin
            rd_key_reg <= key_mem[idx_reg[AW-1:0]];
            rd_val_reg <= val_mem[idx_reg[AW-1:0]];
            rd_idx_reg <= idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (match)
        begin
            slot_reg <= rd_idx_reg;
            hval_reg <= rd_val_reg;
        end
    end

    // recount: walk hash values, residue tracked incrementally
    logic [HN-1:0]        present_reg;
    logic [HN-1:0]        seen_reg;
    logic [HASH_BITS-1:0] h_reg;
    logic [HASH_BITS-1:0] r_reg;
    logic [NW-1:0]        nonempty_reg;
    logic [CMPW-1:0]      r_inc;
    logic                 r_wrap;

    assign r_inc  = CMPW'(r_reg) + CMPW'(1);
    assign r_wrap = (r_inc == CMPW'(bc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            total_reg    <= '0;
            bc_reg       <= BW'(RESET_BUCKETS);
            present_reg  <= '0;
            seen_reg     <= '0;
            h_reg        <= '0;
            r_reg        <= '0;
            nonempty_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (cmd.load)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (insert)
            begin
                total_reg <= total_inc;
                present_reg[hash_reg] <= 1'b1;
                if (grow)
                begin
                    bc_reg <= {bc_reg[BW-2:0], 1'b0};
                end
            end
            else if (cfg_wr_en && (total_reg == '0))
            begin
                bc_reg <= cfg_bc;
            end

            if (cmd.update)
            begin
                h_reg        <= '0;
                r_reg        <= '0;
                seen_reg     <= '0;
                nonempty_reg <= '0;
            end
            else if (cmd.scan)
            begin
                h_reg <= h_reg + 1'b1;
                r_reg <= r_wrap ? '0 : r_inc[HASH_BITS-1:0];
                if (present_reg[h_reg] && !seen_reg[r_reg])
                begin
                    seen_reg[r_reg] <= 1'b1;
                    nonempty_reg    <= nonempty_reg + 1'b1;
                end
            end
        end
    end

    // result word
    logic        status_reg;
    logic        found_reg;
    logic [31:0] vout_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg <= (is_put && !hit_reg && full) ? ST_FULL : ST_OK;
            found_reg  <= hit_reg;
            vout_reg   <= (!is_put && hit_reg) ? hval_reg : 32'd0;
        end
    end

    logic [WIDE-1:0] total_w;
    logic [WIDE-1:0] coll_w;

    assign total_w = WIDE'(total_reg);
    assign coll_w  = total_w - WIDE'(nonempty_reg);

    assign status      = status_reg;
    assign found       = found_reg;
    assign value_out   = vout_reg;
    assign entry_count = total_w[6:0];
    assign collisions  = coll_w[5:0];

    assign sts.search_done = (idx_reg == total_reg) && !rd_vld_reg;
    assign sts.scan_last   = (h_reg == '1);

    `CHM_ASSERT_NOW(a_total_cap, clk, rst_n, 1'b1, total_reg <= CW'(ENTRIES), "entry total overflow")
    `CHM_ASSERT_NOW(a_bc_nonzero, clk, rst_n, 1'b1, bc_reg != '0, "bucket count reached zero")
    `CHM_ASSERT_NOW(a_nonempty_le, clk, rst_n, cmd.scan, WIDE'(nonempty_reg) <= total_w, "more buckets than entries")

endmodule

// ===== rtl/core/chained_hash_map_engine_core.sv =====
// Top level of the chained hash map engine: sequencer plus datapath.
`timescale 1ns / 1ps
// Search streams one entry a cycle, recount walks one hash value a cycle.
// Busy stays high from accept through done; a new word is taken only while busy is low.
// Results are never stalled: done is a single-cycle strobe.
// Reset (rst_n, async low): map empty, bucket count 8; memories need no clearing.
module chained_hash_map_engine_core #(
    parameter int ENTRIES   = chmap_pkg::ENTRIES_DEF,
    parameter int HASH_BITS = chmap_pkg::HASH_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // config: bucket count used while the map is empty
    input  logic                        cfg_wr_en,
    input  logic [chmap_pkg::BKT_W-1:0] cfg_wr_data,
    // request word
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [31:0]                 key,
    input  logic [31:0]                 value,
    // result word
    output logic                        done,
    output logic                        status,
    output logic                        found,
    output logic [31:0]                 value_out,
    output logic [6:0]                  entry_count,
    output logic [5:0]                  collisions
);
    import chmap_pkg::*;

    hm_cmd_t cmd;
    hm_sts_t sts;

    // Sequencer: IDLE -> SEARCH (linear key scan) -> UPDATE (overwrite,
    // insert at the fill count, bucket doubling) -> SCAN (recount of
    // occupied buckets) -> DONE (strobe).
    chmap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Datapath. Entries are never removed, so slots fill in order and the
    // fill count doubles as the valid map: slot i holds data iff i < total.
    // The collision count is total minus occupied buckets; occupancy is
    // rebuilt each word from a per-hash presence vector, tracking
    // hash mod bucket_count with a wrapping counter rather than a divider.
    chmap_dp #(
        .ENTRIES   (ENTRIES),
        .HASH_BITS (HASH_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .status      (status),
        .found       (found),
        .value_out   (value_out),
        .entry_count (entry_count),
        .collisions  (collisions)
    );

endmodule

// ===== tb/chained_hash_map_engine_core_checker.sv =====
// Hash map engine checker: tracks the map, predicts each result word and compares.
`timescale 1ns / 1ps
module chained_hash_map_engine_core_checker
    import chmap_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [BKT_W-1:0]    cfg_wr_data,
    input  logic                start,
    input  logic                busy,
    input  logic                req_type,
    input  logic [31:0]         key,
    input  logic [31:0]         value,
    input  logic                done,
    input  logic                status,
    input  logic                found,
    input  logic [31:0]         value_out,
    input  logic [6:0]          entry_count,
    input  logic [5:0]          collisions,
    output int                  n_outstanding,
    output int                  n_errors
);

    localparam int NSLOT  = ENTRIES_DEF;
    localparam int HB     = HASH_BITS_DEF;
    localparam int GROWTH = 2;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [31:0] value_out;
        logic [6:0]  entry_count;
        logic [5:0]  collisions;
    } map_reply_t;

    // mirror of the map contents
    logic [31:0]   slot_key  [NSLOT];
    logic [31:0]   slot_val  [NSLOT];
    logic [HB-1:0] slot_hash [NSLOT];
    bit            slot_used [NSLOT];
    int            n_stored;
    int            n_buckets;

    map_reply_t    pending_replies[$];

    function automatic logic [HB-1:0] fib_hash(logic [31:0] k);
        logic [31:0] x;
        logic [31:0] p;
        x = k ^ (k >> (32 - HB));
        p = x * FIB_MULT;
        return p[31 -: HB];
    endfunction

    function automatic int count_collisions();
        bit seen [1 << HB];
        int occupied;
        int b;
        occupied = 0;
        for (int i = 0; i < (1 << HB); i++)
            seen[i] = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_used[i])
            begin
                b = int'(slot_hash[i]) % n_buckets;
                if (!seen[b])
                begin
                    seen[b] = 1;
                    occupied++;
                end
            end
        end
        return n_stored - occupied;
    endfunction

    // applies one request to the mirror and returns the word it should produce
    function automatic map_reply_t apply_request(logic rt, logic [31:0] k, logic [31:0] v);
        map_reply_t r;
        int hit;
        int free_slot;
        int ncol;
        r.status = ST_OK;
        r.found = 1'b0;
        r.value_out = '0;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < NSLOT; i++)
            if (hit < 0 && slot_used[i] && slot_key[i] == k)
                hit = i;
        r.found = (hit >= 0);
        if (rt == REQ_GET)
        begin
            if (hit >= 0)
                r.value_out = slot_val[hit];
        end
        else if (hit >= 0)
        begin
            slot_val[hit] = v;
        end
        else
        begin
            for (int i = 0; i < NSLOT; i++)
                if (free_slot < 0 && !slot_used[i])
                    free_slot = i;
            if (free_slot < 0)
                r.status = ST_FULL;
            else
            begin
                slot_key[free_slot]  = k;
                slot_val[free_slot]  = v;
                slot_hash[free_slot] = fib_hash(k);
                slot_used[free_slot] = 1;
                n_stored++;
                if (n_stored > n_buckets * GROWTH)
                    n_buckets = n_buckets * GROWTH;
            end
        end
        ncol = count_collisions();
        r.entry_count = n_stored[6:0];
        r.collisions = ncol[5:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        map_reply_t exp_w;
        map_reply_t got_w;
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
                slot_used[i] = 0;
            n_stored = 0;
            n_buckets = int'(RESET_BUCKETS);
            pending_replies.delete();
            n_outstanding = 0;
            n_errors = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                // bucket count only follows the register while the map is empty
                if (n_stored == 0)
                    n_buckets = (cfg_wr_data == 0) ? 1 : int'(cfg_wr_data);
            end
            // retire before queueing so a same-edge accept can't answer an old word
            if (done)
            begin
                got_w.status = status;
                got_w.found = found;
                got_w.value_out = value_out;
                got_w.entry_count = entry_count;
                got_w.collisions = collisions;
                if (pending_replies.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: result word with none outstanding", $realtime);
                end
                else
                begin
                    exp_w = pending_replies.pop_front();
                    if (got_w !== exp_w)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"%0t: mismatch exp st=%0d fd=%0d val=%h cnt=%0d col=%0d",
                                      " | got st=%0d fd=%0d val=%h cnt=%0d col=%0d"},
                                     $realtime, exp_w.status, exp_w.found, exp_w.value_out,
                                     exp_w.entry_count, exp_w.collisions, got_w.status,
                                     got_w.found, got_w.value_out, got_w.entry_count,
                                     got_w.collisions);
                    end
                end
            end
            if (start && !busy)
                pending_replies.push_back(apply_request(req_type, key, value));
            n_outstanding = pending_replies.size();
        end
    end

endmodule

// ===== tb/chained_hash_map_engine_core_test.sv =====
// Hash map engine testbench top: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module chained_hash_map_engine_core_test;
    import chmap_pkg::*;

    localparam int RAND_WORDS     = 530;
    localparam int PHASE_LEN      = 180;
    localparam int WATCHDOG_LIMIT = 4000;   // well above the worst busy window
    localparam int DRAIN_CYCLES   = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [BKT_W-1:0]   cfg_wr_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic               req_type = REQ_GET;
    logic [31:0]        key = '0;
    logic [31:0]        value = '0;
    logic               done;
    logic               status;
    logic               found;
    logic [31:0]        value_out;
    logic [6:0]         entry_count;
    logic [5:0]         collisions;

    int n_outstanding;
    int n_errors;
    int idle_cycles = 0;

    // keys already sent in a put; reused to hit existing entries
    logic [31:0] put_keys[$];
    // fixed working set of 48 keys, fewer than the 64 slots
    logic [31:0] key_pool[48];
    bit          burst;

    always #2 clk = ~clk;

    chained_hash_map_engine_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found       (found),
        .value_out   (value_out),
        .entry_count (entry_count),
        .collisions  (collisions)
    );

    chained_hash_map_engine_core_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .key           (key),
        .value         (value),
        .done          (done),
        .status        (status),
        .found         (found),
        .value_out     (value_out),
        .entry_count   (entry_count),
        .collisions    (collisions),
        .n_outstanding (n_outstanding),
        .n_errors      (n_errors)
    );

    // Watchdog: any cycle that neither accepts a word nor returns one counts
    // toward the limit; the longest legal quiet stretch is the final drain.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Sends one request word. Called at a falling edge, returns at the falling
    // edge after the word was taken. With gap 0 and no idle wait, start stays
    // high from the previous word, so back-to-back words see no start drop.
    // after_idle holds the word back until busy is gone, which moves the
    // start edge around the block's idle window instead of its busy window.
    task automatic send_word(logic rt, logic [31:0] k, logic [31:0] v, int gap,
                             bit after_idle);
        if (after_idle)
        begin
            start <= 1'b0;
            @(negedge clk);
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        else if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= rt;
        key      <= k;
        value    <= v;
        // busy only moves at rising edges, so low here means the next edge takes it
        while (busy)
            @(negedge clk);
        @(negedge clk);
        if (rt == REQ_PUT)
            put_keys.push_back(k);
    endtask

    // Sender pause: hold off until every outstanding result word is back.
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (n_outstanding != 0 || busy)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_buckets(logic [BKT_W-1:0] n);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45 && put_keys.size() > 0)
            return put_keys[$urandom_range(0, put_keys.size() - 1)];
        else if (sel < 88)
            return key_pool[$urandom_range(0, 47)];
        else
            return $urandom;
    endfunction

    function automatic int pick_gap();
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    initial
    begin
        // directed list: null value, key/value extremes, overwrite, get with
        // a nonzero value field, high key bits for the hash fold, and enough
        // inserts to walk the bucket count from 1 up through 2, 4 and 8
        logic        d_rt  [21];
        logic [31:0] d_key [21];
        logic [31:0] d_val [21];
        logic        rt;
        logic [31:0] v;

        d_rt = '{REQ_GET, REQ_PUT, REQ_GET, REQ_PUT, REQ_GET, REQ_PUT, REQ_GET,
                 REQ_PUT, REQ_PUT, REQ_PUT, REQ_PUT, REQ_PUT, REQ_PUT, REQ_PUT,
                 REQ_PUT, REQ_PUT, REQ_GET, REQ_GET, REQ_PUT, REQ_GET, REQ_GET};
        d_key = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
                  32'h8000_0000, 32'hE000_0000, 32'h2000_0000, 32'h1, 32'h2, 32'h3,
                  32'h4, 32'h5, 32'h6, 32'h3, 32'h0001_2345, 32'h3, 32'h3,
                  32'hE000_0000};
        d_val = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hA5A5_A5A5,
                  32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h11, 32'h22, 32'h33,
                  32'h44, 32'h55, 32'h66, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

        for (int i = 0; i < 48; i++)
            key_pool[i] = $urandom;
        burst = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // largest bucket count first, checked on an empty map, then zero
        // (taken as one bucket) so the growth chain runs from the bottom
        write_buckets(7'd64);
        send_word(REQ_GET, 32'h1357_9BDF, 32'h0, 0, 0);
        settle();
        write_buckets(7'd0);

        for (int i = 0; i < 21; i++)
            send_word(d_rt[i], d_key[i], d_val[i], $urandom_range(0, 4),
                      $urandom_range(0, 1));
        settle();
        write_buckets(7'd1);

        // random part: mostly hits on known keys and a fixed working set,
        // a few fresh keys; burst stretches run with no gaps at all
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            if (n == PHASE_LEN)
            begin
                // map is non-empty now: register moves, bucket count must not
                settle();
                write_buckets(7'd63);
            end
            else if (n == 2 * PHASE_LEN)
            begin
                settle();
                write_buckets(7'($urandom_range(1, 64)));
            end
            else if ($urandom_range(0, 49) == 0)
                settle();
            rt = $urandom_range(0, 1) ? REQ_GET : REQ_PUT;
            v = ($urandom_range(0, 19) == 0) ? 32'h0 : 32'($urandom);
            send_word(rt, pick_key(), v, pick_gap(), !burst && $urandom_range(0, 1));
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (n_errors == 0 && n_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== chained_hash_map_engine_core.f =====
+incdir+rtl/core
rtl/core/chmap_pkg.sv
rtl/core/chmap_ctrl.sv
rtl/core/chmap_dp.sv
rtl/core/chained_hash_map_engine_core.sv
tb/chained_hash_map_engine_core_checker.sv
tb/chained_hash_map_engine_core_test.sv
